// ----- design/rfbd_pkg.sv -----
`default_nettype none
package rfbd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int NUM_CHANNELS = 3;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDE_PIXELS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RED_SHIFT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GREEN_SHIFT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLUE_SHIFT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RED_MAX = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GREEN_MAX = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLUE_MAX = 3'd6;

   localparam logic RESET_WIDE_PIXELS = 1'b1;
   localparam logic [4:0] RESET_RED_SHIFT = 5'd16;
   localparam logic [4:0] RESET_GREEN_SHIFT = 5'd8;
   localparam logic [4:0] RESET_BLUE_SHIFT = 5'd0;
   localparam logic [15:0] RESET_CHANNEL_MAX = 16'd255;

   typedef enum logic [2:0] {
      PH_PAD,
      PH_COUNT,
      PH_X,
      PH_Y,
      PH_W,
      PH_H,
      PH_ENC,
      PH_PIXELS
   } phase_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_WAIT
   } back_state_type;

   // one pixel or end marker handed from the parser to the scaler
   typedef struct packed {
      logic [31:0] pix;
      logic [16:0] x;
      logic [16:0] y;
      logic        pixel_valid;
      logic        last_of_update;
   } pixel_cmd_type;

   // channel order: 0 red, 1 green, 2 blue
   typedef struct packed {
      logic [NUM_CHANNELS-1:0][4:0]  shift;
      logic [NUM_CHANNELS-1:0][15:0] max;
   } scale_cfg_type;

   typedef struct packed {
      logic [16:0] rem;
      logic        q;
   } div_step_type;

   // one restoring division step, remainder always below the divisor
   function automatic div_step_type div_step(input logic [16:0] rem,
                                             input logic [16:0] divisor);
      logic [17:0]  dbl;
      div_step_type res;
      dbl = {rem, 1'b0};
      if (dbl >= {1'b0, divisor}) begin
         res.rem = 17'(dbl - {1'b0, divisor});
         res.q = 1'b1;
      end else begin
         res.rem = dbl[16:0];
         res.q = 1'b0;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- design/raw_framebuffer_update_decoder_core.sv -----
`default_nettype none
// Decodes the body of a remote-framebuffer update (everything after the message
// type byte) one byte per accepted item, taking every rectangle as raw and
// emitting one item per complete pixel with its screen position and 8-bit red,
// green and blue, each scaled as (field & max) * 256 / (max + 1); an update with
// no rectangles, or ending on an empty rectangle, gives one bare end marker.
// A byte parser accepts one byte per cycle and hands pixels to a 4-entry queue;
// the scaler behind it takes one pixel at a time through a load and then four
// radix-4 division steps, run in parallel for the three channels, and bytes are
// stalled only while the queue is full. Configuration registers are read live and
// should be written with the block idle.
module raw_framebuffer_update_decoder_core #(
   parameter int QUEUE_DEPTH = rfbd_pkg::QUEUE_DEPTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_data_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [16:0]                               rsp_pixel_x,
   output logic [16:0]                               rsp_pixel_y,
   output logic [7:0]                                rsp_red,
   output logic [7:0]                                rsp_green,
   output logic [7:0]                                rsp_blue,
   output logic                                      rsp_pixel_valid,
   output logic                                      rsp_last_of_update,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rfbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rfbd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic        wide_ff, wide_in;
   logic [4:0]  r_shift_ff, r_shift_in;
   logic [4:0]  g_shift_ff, g_shift_in;
   logic [4:0]  b_shift_ff, b_shift_in;
   logic [15:0] r_limit_ff, r_limit_in;
   logic [15:0] g_limit_ff, g_limit_in;
   logic [15:0] b_limit_ff, b_limit_in;

   rfbd_pkg::scale_cfg_type scale_cfg;
   rfbd_pkg::pixel_cmd_type push_cmd;
   rfbd_pkg::pixel_cmd_type head_cmd;
   logic push_valid;
   logic queue_full;
   logic head_valid;
   logic pop;
   logic byte_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= rfbd_pkg::RESET_WIDE_PIXELS;
         r_shift_ff <= rfbd_pkg::RESET_RED_SHIFT;
         g_shift_ff <= rfbd_pkg::RESET_GREEN_SHIFT;
         b_shift_ff <= rfbd_pkg::RESET_BLUE_SHIFT;
         r_limit_ff <= rfbd_pkg::RESET_CHANNEL_MAX;
         g_limit_ff <= rfbd_pkg::RESET_CHANNEL_MAX;
         b_limit_ff <= rfbd_pkg::RESET_CHANNEL_MAX;
      end else begin
         wide_ff <= wide_in;
         r_shift_ff <= r_shift_in;
         g_shift_ff <= g_shift_in;
         b_shift_ff <= b_shift_in;
         r_limit_ff <= r_limit_in;
         g_limit_ff <= g_limit_in;
         b_limit_ff <= b_limit_in;
      end
   end

   always_comb begin
      wide_in = wide_ff;
      r_shift_in = r_shift_ff;
      g_shift_in = g_shift_ff;
      b_shift_in = b_shift_ff;
      r_limit_in = r_limit_ff;
      g_limit_in = g_limit_ff;
      b_limit_in = b_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rfbd_pkg::CSR_WIDE_PIXELS: wide_in = csr_write_data[0];
            rfbd_pkg::CSR_RED_SHIFT:   r_shift_in = csr_write_data[4:0];
            rfbd_pkg::CSR_GREEN_SHIFT: g_shift_in = csr_write_data[4:0];
            rfbd_pkg::CSR_BLUE_SHIFT:  b_shift_in = csr_write_data[4:0];
            rfbd_pkg::CSR_RED_MAX:     r_limit_in = csr_write_data;
            rfbd_pkg::CSR_GREEN_MAX:   g_limit_in = csr_write_data;
            rfbd_pkg::CSR_BLUE_MAX:    b_limit_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign scale_cfg.shift = {b_shift_ff, g_shift_ff, r_shift_ff};
   assign scale_cfg.max = {b_limit_ff, g_limit_ff, r_limit_ff};

   // any byte may produce an item, so hold off input while the queue is full
   assign req_stall = queue_full;
   assign byte_accept = req_valid && !queue_full;

   rfbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_data_byte),
      .wide_pixels (wide_ff),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   rfbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   rfbd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .scale_cfg          (scale_cfg),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_pixel_valid    (rsp_pixel_valid),
      .rsp_last_of_update (rsp_last_of_update)
   );

endmodule
`default_nettype wire

// ----- design/rfbd_front.sv -----
`default_nettype none
module rfbd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_accept,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   wide_pixels,
   output logic                        push_valid,
   output rfbd_pkg::pixel_cmd_type     push_cmd
);

   rfbd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] rects_ff, rects_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [15:0] rect_x_ff, rect_x_in;
   logic [15:0] rect_y_ff, rect_y_in;
   logic [15:0] rect_w_ff, rect_w_in;
   logic [15:0] rect_h_ff, rect_h_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [31:0] asm_ff, asm_in;

   logic [31:0] asm_next;
   logic [15:0] hdr_next;
   logic [1:0]  pix_need;
   logic [1:0]  hdr_need;
   logic        end_last;
   logic        close_rect;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rfbd_pkg::PH_PAD;
         count_ff <= '0;
         rects_ff <= '0;
         hdr_ff <= '0;
         rect_x_ff <= '0;
         rect_y_ff <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         asm_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         rects_ff <= rects_in;
         hdr_ff <= hdr_in;
         rect_x_ff <= rect_x_in;
         rect_y_ff <= rect_y_in;
         rect_w_ff <= rect_w_in;
         rect_h_ff <= rect_h_in;
         col_ff <= col_in;
         row_ff <= row_in;
         asm_ff <= asm_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      rects_in = rects_ff;
      hdr_in = hdr_ff;
      rect_x_in = rect_x_ff;
      rect_y_in = rect_y_ff;
      rect_w_in = rect_w_ff;
      rect_h_in = rect_h_ff;
      col_in = col_ff;
      row_in = row_ff;
      asm_in = asm_ff;
      push_valid = 1'b0;
      push_cmd = '0;
      close_rect = 1'b0;

      // pixels arrive little-endian, header words big-endian
      asm_next = asm_ff | (32'(data_byte) << {count_ff, 3'b000});
      hdr_next = {hdr_ff[7:0], data_byte};
      pix_need = wide_pixels ? 2'd3 : 2'd1;
      hdr_need = (phase_ff == rfbd_pkg::PH_ENC) ? 2'd3 : 2'd1;
      end_last = (rects_ff <= 16'd1);

      if (byte_accept) begin
         unique case (phase_ff)
            rfbd_pkg::PH_PIXELS: begin
               if (count_ff < pix_need) begin
                  count_in = count_ff + 2'd1;
                  asm_in = asm_next;
               end else begin
                  push_valid = 1'b1;
                  push_cmd.pix = wide_pixels ? asm_next : {16'd0, asm_next[15:0]};
                  push_cmd.x = 17'(rect_x_ff) + 17'(col_ff);
                  push_cmd.y = 17'(rect_y_ff) + 17'(row_ff);
                  push_cmd.pixel_valid = 1'b1;
                  count_in = '0;
                  asm_in = '0;
                  if ((17'(col_ff) + 17'd1) >= 17'(rect_w_ff)) begin
                     col_in = '0;
                     if ((17'(row_ff) + 17'd1) >= 17'(rect_h_ff)) begin
                        row_in = '0;
                        close_rect = 1'b1;
                        push_cmd.last_of_update = end_last;
                     end else begin
                        row_in = row_ff + 16'd1;
                     end
                  end else begin
                     col_in = col_ff + 16'd1;
                  end
               end
            end
            rfbd_pkg::PH_COUNT, rfbd_pkg::PH_X, rfbd_pkg::PH_Y, rfbd_pkg::PH_W,
            rfbd_pkg::PH_H, rfbd_pkg::PH_ENC: begin
               if (count_ff < hdr_need) begin
                  count_in = count_ff + 2'd1;
                  hdr_in = hdr_next;
               end else begin
                  count_in = '0;
                  hdr_in = '0;
                  unique case (phase_ff)
                     rfbd_pkg::PH_COUNT: begin
                        if (hdr_next == 16'd0) begin
                           rects_in = '0;
                           phase_in = rfbd_pkg::PH_PAD;
                           push_valid = 1'b1;
                           push_cmd.last_of_update = 1'b1;
                        end else begin
                           rects_in = hdr_next;
                           phase_in = rfbd_pkg::PH_X;
                        end
                     end
                     rfbd_pkg::PH_X: begin
                        rect_x_in = hdr_next;
                        phase_in = rfbd_pkg::PH_Y;
                     end
                     rfbd_pkg::PH_Y: begin
                        rect_y_in = hdr_next;
                        phase_in = rfbd_pkg::PH_W;
                     end
                     rfbd_pkg::PH_W: begin
                        rect_w_in = hdr_next;
                        phase_in = rfbd_pkg::PH_H;
                     end
                     rfbd_pkg::PH_H: begin
                        rect_h_in = hdr_next;
                        phase_in = rfbd_pkg::PH_ENC;
                     end
                     default: begin
                        // encoding word is dropped, rectangle taken as raw
                        col_in = '0;
                        row_in = '0;
                        asm_in = '0;
                        if (rect_w_ff == 16'd0 || rect_h_ff == 16'd0) begin
                           close_rect = 1'b1;
                           push_valid = end_last;
                           push_cmd.last_of_update = 1'b1;
                        end else begin
                           phase_in = rfbd_pkg::PH_PIXELS;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // padding byte
               phase_in = rfbd_pkg::PH_COUNT;
               count_in = '0;
               hdr_in = '0;
            end
         endcase

         if (close_rect) begin
            count_in = '0;
            if (end_last) begin
               rects_in = '0;
               phase_in = rfbd_pkg::PH_PAD;
            end else begin
               rects_in = rects_ff - 16'd1;
               phase_in = rfbd_pkg::PH_X;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- design/rfbd_queue.sv -----
`default_nettype none
module rfbd_queue #(
   parameter int DEPTH = rfbd_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   input  rfbd_pkg::pixel_cmd_type      push_cmd,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         head_valid,
   output rfbd_pkg::pixel_cmd_type      head_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rfbd_pkg::pixel_cmd_type entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- design/rfbd_back.sv -----
`default_nettype none
module rfbd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  rfbd_pkg::pixel_cmd_type   head_cmd,
   input  rfbd_pkg::scale_cfg_type   scale_cfg,
   output logic                      pop,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [16:0]               rsp_pixel_x,
   output logic [16:0]               rsp_pixel_y,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic                      rsp_pixel_valid,
   output logic                      rsp_last_of_update
);

   localparam int NCH = rfbd_pkg::NUM_CHANNELS;

   rfbd_pkg::back_state_type state_ff, state_in;
   logic [1:0]  step_ff, step_in;
   logic [16:0] rem_ff [NCH];
   logic [16:0] rem_in [NCH];
   logic [16:0] div_ff [NCH];
   logic [16:0] div_in [NCH];
   logic [7:0]  quo_ff [NCH];
   logic [7:0]  quo_in [NCH];
   logic [16:0] x_ff, x_in;
   logic [16:0] y_ff, y_in;
   logic        pv_ff, pv_in;
   logic        last_ff, last_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_x_ff, rsp_x_in;
   logic [16:0] rsp_y_ff, rsp_y_in;
   logic [7:0]  rsp_r_ff, rsp_r_in;
   logic [7:0]  rsp_g_ff, rsp_g_in;
   logic [7:0]  rsp_b_ff, rsp_b_in;
   logic        rsp_pv_ff, rsp_pv_in;
   logic        rsp_last_ff, rsp_last_in;

   rfbd_pkg::div_step_type first_step [NCH];
   rfbd_pkg::div_step_type second_step [NCH];
   logic [31:0] shifted [NCH];
   logic        out_free;
   logic        load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_x = rsp_x_ff;
   assign rsp_pixel_y = rsp_y_ff;
   assign rsp_red = rsp_r_ff;
   assign rsp_green = rsp_g_ff;
   assign rsp_blue = rsp_b_ff;
   assign rsp_pixel_valid = rsp_pv_ff;
   assign rsp_last_of_update = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfbd_pkg::BACK_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NCH; c++) begin
         rem_ff[c] <= rem_in[c];
         div_ff[c] <= div_in[c];
         quo_ff[c] <= quo_in[c];
      end
      x_ff <= x_in;
      y_ff <= y_in;
      pv_ff <= pv_in;
      last_ff <= last_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_r_ff <= rsp_r_in;
      rsp_g_ff <= rsp_g_in;
      rsp_b_ff <= rsp_b_in;
      rsp_pv_ff <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      pv_in = pv_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_r_in = rsp_r_ff;
      rsp_g_in = rsp_g_ff;
      rsp_b_in = rsp_b_ff;
      rsp_pv_in = rsp_pv_ff;
      rsp_last_in = rsp_last_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      load = 1'b0;

      for (int c = 0; c < NCH; c++) begin
         rem_in[c] = rem_ff[c];
         div_in[c] = div_ff[c];
         quo_in[c] = quo_ff[c];
         // two quotient bits a cycle
         first_step[c] = rfbd_pkg::div_step(rem_ff[c], div_ff[c]);
         second_step[c] = rfbd_pkg::div_step(first_step[c].rem, div_ff[c]);
         shifted[c] = head_cmd.pix >> scale_cfg.shift[c];
      end

      unique case (state_ff)
         rfbd_pkg::BACK_IDLE: begin
            load = head_valid;
         end
         rfbd_pkg::BACK_DIVIDE: begin
            for (int c = 0; c < NCH; c++) begin
               rem_in[c] = second_step[c].rem;
               quo_in[c] = {quo_ff[c][5:0], first_step[c].q, second_step[c].q};
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = rfbd_pkg::BACK_WAIT;
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = x_ff;
               rsp_y_in = y_ff;
               rsp_r_in = quo_ff[0];
               rsp_g_in = quo_ff[1];
               rsp_b_in = quo_ff[2];
               rsp_pv_in = pv_ff;
               rsp_last_in = last_ff;
               state_in = rfbd_pkg::BACK_IDLE;
               load = head_valid;
            end
         end
      endcase

      if (load) begin
         // quotient of field*256/(max+1) fits eight bits since field <= max
         for (int c = 0; c < NCH; c++) begin
            rem_in[c] = {1'b0, shifted[c][15:0] & scale_cfg.max[c]};
            div_in[c] = {1'b0, scale_cfg.max[c]} + 17'd1;
            quo_in[c] = '0;
         end
         x_in = head_cmd.x;
         y_in = head_cmd.y;
         pv_in = head_cmd.pixel_valid;
         last_in = head_cmd.last_of_update;
         step_in = '0;
         state_in = rfbd_pkg::BACK_DIVIDE;
      end
      pop = load;
   end

endmodule
`default_nettype wire
